// ===== hdl/zrsp_pkg.sv =====
`timescale 1ns / 1ps
// Package: shared constants and types for the zero-run sample packer.
package zrsp_pkg;

	localparam int SampleW   = 8;
	localparam int MaxBytes  = 3;
	localparam int NumW      = $clog2(MaxBytes + 1);
	localparam int IdxW      = $clog2(MaxBytes);
	localparam int QueueDepth = 4;
	localparam int QPtrW     = $clog2(QueueDepth);
	localparam int QCntW     = $clog2(QueueDepth + 1);
	localparam int ApbAddrW  = 3;
	localparam int ApbDataW  = 32;

	localparam logic [SampleW-1:0] MarkerByte = 8'hFF;
	localparam logic [SampleW-1:0] ClampMax   = 8'd254;
	localparam logic [SampleW-1:0] RunLimit   = 8'd254;
	localparam logic [SampleW-1:0] ZeroByte   = 8'd0;
	localparam logic [SampleW-1:0] ThreshRst  = 8'd1;

	// register index, taken from paddr[2]
	localparam logic RegZeroThreshold = 1'b0;

	// bytes caused by one input word, in send order
	typedef struct packed {
		logic [NumW-1:0]                  num;
		logic [MaxBytes-1:0][SampleW-1:0] data;
	} zrsp_entry_t;

	function automatic logic [SampleW-1:0] clamp_sample(input logic [SampleW-1:0] s);
		return (s > ClampMax) ? ClampMax : s;
	endfunction

endpackage

// ===== hdl/zrsp_if.sv =====
`timescale 1ns / 1ps
// Interfaces: sample input channel and packed byte output channel.
interface zrsp_in_if;
	logic                        valid;
	logic                        ready;
	logic [zrsp_pkg::SampleW-1:0] sample;
	logic                        raw_mode;
	logic                        frame_start;
	logic                        frame_end;

	modport source (output valid, sample, raw_mode, frame_start, frame_end, input ready);
	modport sink   (input valid, sample, raw_mode, frame_start, frame_end, output ready);
endinterface

interface zrsp_out_if;
	logic                        valid;
	logic                        ready;
	logic [zrsp_pkg::SampleW-1:0] out_byte;
	logic                        last_of_item;

	modport source (output valid, out_byte, last_of_item, input ready);
	modport sink   (input valid, out_byte, last_of_item, output ready);
endinterface

// ===== hdl/zero_run_sample_packer.sv =====
`timescale 1ns / 1ps
// Top level of the zero-run sample packer.
//
// samples: one word per sample with raw_mode, frame_start and frame_end flags,
//   valid/ready handshake. stream: packed bytes, one word per byte, with
//   last_of_item set on the final byte a sample caused. A sample below the
//   zero_threshold register (compressed mode) may cause no byte at all.
// APB port: zero_threshold at address 0, reset value 1; write it only while
//   the block is idle.
// Path: a sample's bytes are written into the queue at the edge that takes
//   the sample, then pass through the output register onto stream.
// Throughput: samples are taken every cycle while the four-entry group queue
//   has room; stream moves one byte per cycle while ready is high, so each
//   byte of a sample takes its own slot. The output port sets the sustained rate.
// Reset clears the run count, the queue and the output valid; the threshold
//   returns to 1.
// When the receiver stalls, the output register holds its byte, the queue
//   fills, and samples.ready drops once the queue is full.
module zero_run_sample_packer (
	input  logic                          clk,
	input  logic                          arst_n,
	zrsp_in_if.sink                       samples,
	zrsp_out_if.source                    stream,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [zrsp_pkg::ApbAddrW-1:0] paddr,
	input  logic [zrsp_pkg::ApbDataW-1:0] pwdata,
	output logic [zrsp_pkg::ApbDataW-1:0] prdata,
	output logic                          pready
);

	logic [zrsp_pkg::SampleW-1:0] threshold_q;
	logic                         queue_full;
	logic                         push;
	logic                         pop;
	logic                         head_valid;
	zrsp_pkg::zrsp_entry_t        push_entry;
	zrsp_pkg::zrsp_entry_t        head;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == zrsp_pkg::RegZeroThreshold)
		? zrsp_pkg::ApbDataW'(threshold_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= zrsp_pkg::ThreshRst;
		end else if (psel && penable && pwrite && pready
			&& (paddr[2] == zrsp_pkg::RegZeroThreshold)) begin
			threshold_q <= pwdata[zrsp_pkg::SampleW-1:0];
		end
	end

	zrsp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.samples    (samples),
		.threshold  (threshold_q),
		.queue_full (queue_full),
		.push       (push),
		.push_entry (push_entry)
	);

	zrsp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (queue_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	zrsp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.stream     (stream)
	);

endmodule

// ===== hdl/zrsp_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts samples, tracks the zero run and forms the byte group per word.
module zrsp_front (
	input  logic                         clk,
	input  logic                         arst_n,
	zrsp_in_if.sink                      samples,
	input  logic [zrsp_pkg::SampleW-1:0] threshold,
	input  logic                         queue_full,
	output logic                         push,
	output zrsp_pkg::zrsp_entry_t        push_entry
);

	logic [zrsp_pkg::SampleW-1:0] run_cnt_q;
	logic [zrsp_pkg::SampleW-1:0] run_nxt;
	logic                         accept;

	assign samples.ready = !queue_full;
	assign accept        = samples.valid && samples.ready;
	assign push          = accept && (push_entry.num != '0);

	always_comb begin
		logic [zrsp_pkg::MaxBytes:0][zrsp_pkg::SampleW-1:0] b;
		logic [zrsp_pkg::NumW-1:0]                          n;
		logic [zrsp_pkg::SampleW-1:0]                       cnt;
		b   = '0;
		n   = '0;
		cnt = run_cnt_q;

		if (samples.frame_start) begin
			b[n] = zrsp_pkg::MarkerByte;
			n    = n + 2'd1;
			cnt  = '0;
		end

		if (samples.raw_mode) begin
			b[n] = zrsp_pkg::clamp_sample(samples.sample);
			n    = n + 2'd1;
		end else if (samples.sample < threshold) begin
			if (cnt < zrsp_pkg::RunLimit - 8'd1) begin
				cnt = cnt + 8'd1;
			end else begin
				// full run: 0, 254
				b[n]        = zrsp_pkg::ZeroByte;
				b[n + 2'd1] = zrsp_pkg::RunLimit;
				n           = n + 2'd2;
				cnt         = '0;
			end
		end else begin
			if (cnt != '0) begin
				b[n]        = zrsp_pkg::ZeroByte;
				b[n + 2'd1] = cnt;
				n           = n + 2'd2;
				cnt         = '0;
			end
			b[n] = zrsp_pkg::clamp_sample(samples.sample);
			n    = n + 2'd1;
		end

		if (samples.frame_end && (cnt != '0)) begin
			b[n]        = zrsp_pkg::ZeroByte;
			b[n + 2'd1] = cnt;
			n           = n + 2'd2;
			cnt         = '0;
		end

		push_entry.num  = n;
		push_entry.data = b[zrsp_pkg::MaxBytes-1:0];
		run_nxt         = cnt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_cnt_q <= '0;
		end else if (accept) begin
			run_cnt_q <= run_nxt;
		end
	end

endmodule

// ===== hdl/zrsp_queue.sv =====
`timescale 1ns / 1ps
// Small queue of byte groups between the front and back ends.
module zrsp_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  zrsp_pkg::zrsp_entry_t push_entry,
	output logic                  full,
	input  logic                  pop,
	output logic                  head_valid,
	output zrsp_pkg::zrsp_entry_t head
);

	zrsp_pkg::zrsp_entry_t          entries_q [zrsp_pkg::QueueDepth];
	logic [zrsp_pkg::QPtrW-1:0]     wr_ptr_q;
	logic [zrsp_pkg::QPtrW-1:0]     rd_ptr_q;
	logic [zrsp_pkg::QCntW-1:0]     fill_q;

	assign full       = (fill_q == zrsp_pkg::QCntW'(zrsp_pkg::QueueDepth));
	assign head_valid = (fill_q != '0);
	assign head       = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

// ===== hdl/zrsp_back.sv =====
`timescale 1ns / 1ps
// Back end: sends each byte group through an output register, one byte per cycle while stream.ready is high.
module zrsp_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  head_valid,
	input  zrsp_pkg::zrsp_entry_t head,
	output logic                  pop,
	zrsp_out_if.source            stream
);

	logic [zrsp_pkg::IdxW-1:0]    idx_q;
	logic                         valid_q;
	logic [zrsp_pkg::SampleW-1:0] byte_q;
	logic                         last_q;
	logic                         load;
	logic                         final_byte;

	assign load       = head_valid && (!valid_q || stream.ready);
	assign final_byte = (zrsp_pkg::NumW'(idx_q) == head.num - 2'd1);
	assign pop        = load && final_byte;

	assign stream.valid        = valid_q;
	assign stream.out_byte     = byte_q;
	assign stream.last_of_item = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= final_byte ? '0 : idx_q + 1'b1;
			end else if (stream.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= head.data[idx_q];
			last_q <= final_byte;
		end
	end

endmodule

// ===== hdl/zrsp_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the zero-run sample packer, with its bind.
module zrsp_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          stream_valid,
	input logic                          stream_ready,
	input logic [zrsp_pkg::SampleW-1:0]  stream_byte,
	input logic                          stream_last,
	input logic                          psel,
	input logic                          penable,
	input logic                          pwrite,
	input logic [zrsp_pkg::ApbAddrW-1:0] paddr,
	input logic [zrsp_pkg::ApbDataW-1:0] pwdata,
	input logic [zrsp_pkg::ApbDataW-1:0] prdata
);

	logic prev_last_q;

	// last_of_item of the most recent byte taken; start of stream counts as a boundary
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_last_q <= 1'b1;
		end else if (stream_valid && stream_ready) begin
			prev_last_q <= stream_last;
		end
	end

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		stream_valid && !stream_ready |=> stream_valid)
		else $error("stream valid dropped while stalled");

	a_payload_hold: assert property (@(posedge clk) disable iff (!arst_n)
		stream_valid && !stream_ready |=> $stable(stream_byte) && $stable(stream_last))
		else $error("stream word changed while stalled");

	// data bytes are clamped, so a marker can only open a sample's byte group
	a_marker_first: assert property (@(posedge clk) disable iff (!arst_n)
		stream_valid && (stream_byte == zrsp_pkg::MarkerByte) |-> prev_last_q)
		else $error("marker byte inside a byte group");

	a_thresh_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && (paddr[2] == zrsp_pkg::RegZeroThreshold)
		|=> (paddr[2] != zrsp_pkg::RegZeroThreshold)
			|| (prdata == zrsp_pkg::ApbDataW'($past(pwdata[zrsp_pkg::SampleW-1:0]))))
		else $error("threshold readback mismatch");

endmodule

bind zero_run_sample_packer zrsp_checker u_zrsp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.stream_valid (stream.valid),
	.stream_ready (stream.ready),
	.stream_byte  (stream.out_byte),
	.stream_last  (stream.last_of_item),
	.psel         (psel),
	.penable      (penable),
	.pwrite       (pwrite),
	.paddr        (paddr),
	.pwdata       (pwdata),
	.prdata       (prdata)
);

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// Testbench: directed and random sample words against a run-length packing predictor.
module tb;
	import zrsp_pkg::SampleW;
	import zrsp_pkg::ApbAddrW;
	import zrsp_pkg::ApbDataW;

	localparam logic [SampleW-1:0]  Marker  = 8'hFF;
	localparam logic [SampleW-1:0]  Clamp   = 8'd254;
	localparam logic [SampleW-1:0]  RunFull = 8'd254;
	localparam logic [ApbAddrW-1:0] AddrZeroThreshold = '0;
	localparam int NumRows  = 25;
	localparam int PhaseLen = 34;
	localparam int Drain    = 8;
	localparam int Limit    = 200000;

	typedef struct packed {
		logic [SampleW-1:0] sample;
		logic               raw_mode;
		logic               frame_start;
		logic               frame_end;
	} word_t;

	typedef struct packed {
		logic [SampleW-1:0] out_byte;
		logic               last_of_item;
	} byte_t;

	// typed rows carry their expected bytes; the rest go through pack_word
	typedef struct packed {
		word_t                   w;
		logic                    typed;
		logic [1:0]              n;
		logic [0:2][SampleW-1:0] b;
	} row_t;

	// threshold stays 1 (reset value) for the whole table
	localparam row_t Directed [NumRows] = '{
		'{'{8'd0,   1'b0, 1'b1, 1'b0}, 1'b1, 2'd1, '{Marker, 8'd0, 8'd0}},
		'{'{8'd0,   1'b0, 1'b0, 1'b0}, 1'b1, 2'd0, '{8'd0, 8'd0, 8'd0}},
		'{'{8'd5,   1'b0, 1'b0, 1'b0}, 1'b0, 2'd0, '{8'd0, 8'd0, 8'd0}},
		'{'{8'd255, 1'b0, 1'b0, 1'b0}, 1'b1, 2'd1, '{8'd254, 8'd0, 8'd0}},
		'{'{8'd254, 1'b0, 1'b0, 1'b0}, 1'b1, 2'd1, '{8'd254, 8'd0, 8'd0}},
		'{'{8'd1,   1'b0, 1'b0, 1'b0}, 1'b1, 2'd1, '{8'd1, 8'd0, 8'd0}},
		'{'{8'd255, 1'b1, 1'b0, 1'b0}, 1'b1, 2'd1, '{8'd254, 8'd0, 8'd0}},
		'{'{8'd0,   1'b0, 1'b0, 1'b0}, 1'b1, 2'd0, '{8'd0, 8'd0, 8'd0}},
		'{'{8'd0,   1'b1, 1'b0, 1'b0}, 1'b1, 2'd1, '{8'd0, 8'd0, 8'd0}},
		'{'{8'd128, 1'b1, 1'b0, 1'b1}, 1'b0, 2'd0, '{8'd0, 8'd0, 8'd0}},
		'{'{8'd0,   1'b0, 1'b0, 1'b1}, 1'b1, 2'd2, '{8'd0, 8'd1, 8'd0}},
		'{'{8'd0,   1'b0, 1'b0, 1'b0}, 1'b1, 2'd0, '{8'd0, 8'd0, 8'd0}},
		'{'{8'd0,   1'b0, 1'b1, 1'b0}, 1'b1, 2'd1, '{Marker, 8'd0, 8'd0}},
		'{'{8'd77,  1'b0, 1'b1, 1'b1}, 1'b0, 2'd0, '{8'd0, 8'd0, 8'd0}},
		'{'{8'd0,   1'b1, 1'b1, 1'b1}, 1'b1, 2'd2, '{Marker, 8'd0, 8'd0}},
		'{'{8'd0,   1'b0, 1'b1, 1'b1}, 1'b1, 2'd3, '{Marker, 8'd0, 8'd1}},
		'{'{8'd200, 1'b0, 1'b0, 1'b1}, 1'b1, 2'd1, '{8'd200, 8'd0, 8'd0}},
		'{'{8'd0,   1'b0, 1'b0, 1'b0}, 1'b1, 2'd0, '{8'd0, 8'd0, 8'd0}},
		'{'{8'd0,   1'b0, 1'b0, 1'b0}, 1'b1, 2'd0, '{8'd0, 8'd0, 8'd0}},
		'{'{8'd0,   1'b1, 1'b1, 1'b0}, 1'b1, 2'd2, '{Marker, 8'd0, 8'd0}},
		'{'{8'd9,   1'b0, 1'b0, 1'b0}, 1'b1, 2'd1, '{8'd9, 8'd0, 8'd0}},
		'{'{8'd255, 1'b1, 1'b0, 1'b1}, 1'b1, 2'd1, '{8'd254, 8'd0, 8'd0}},
		'{'{8'd0,   1'b0, 1'b0, 1'b0}, 1'b1, 2'd0, '{8'd0, 8'd0, 8'd0}},
		'{'{8'd255, 1'b1, 1'b0, 1'b0}, 1'b1, 2'd1, '{8'd254, 8'd0, 8'd0}},
		'{'{8'd3,   1'b0, 1'b0, 1'b1}, 1'b0, 2'd0, '{8'd0, 8'd0, 8'd0}}
	};

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ApbAddrW-1:0] paddr;
	logic [ApbDataW-1:0] pwdata;
	logic [ApbDataW-1:0] prdata;
	logic                pready;

	zrsp_in_if  in_if ();
	zrsp_out_if out_if ();

	zero_run_sample_packer u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (in_if),
		.stream  (out_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	logic [SampleW-1:0] threshold;
	logic [SampleW-1:0] zero_run;
	logic [SampleW-1:0] pred_bytes [0:2];
	byte_t              expected_bytes [$];
	int                 mismatches;
	int                 cycles;
	bit                 steady;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > Limit) begin
			$display("%0t: timeout, %0d bytes outstanding", $time, expected_bytes.size());
			$display("[zero_run_sample_packer] ERROR");
			$finish;
		end
	end

	// Bytes one sample word produces; updates the run count.
	function automatic int pack_word(input word_t w);
		logic [SampleW-1:0] s;
		int n;
		n = 0;
		s = (w.sample > Clamp) ? Clamp : w.sample;
		if (w.frame_start) begin
			pred_bytes[n] = Marker;
			n += 1;
			zero_run = '0;
		end
		if (w.raw_mode) begin
			pred_bytes[n] = s;
			n += 1;
		end else if (w.sample < threshold) begin
			if (zero_run < RunFull - 1) begin
				zero_run = zero_run + 1'b1;
			end else begin
				pred_bytes[n] = '0;
				pred_bytes[n+1] = RunFull;
				n += 2;
				zero_run = '0;
			end
		end else begin
			if (zero_run != 0) begin
				pred_bytes[n] = '0;
				pred_bytes[n+1] = zero_run;
				n += 2;
				zero_run = '0;
			end
			pred_bytes[n] = s;
			n += 1;
		end
		if (w.frame_end && zero_run != 0) begin
			pred_bytes[n] = '0;
			pred_bytes[n+1] = zero_run;
			n += 2;
			zero_run = '0;
		end
		return n;
	endfunction

	// Called at a rising edge; returns at the edge that takes the word.
	task automatic send_word(input row_t r);
		int n;
		while (!steady && $urandom_range(0, 99) < 31) begin
			in_if.valid <= 1'b0;
			@(posedge clk);
		end
		in_if.valid       <= 1'b1;
		in_if.sample      <= r.w.sample;
		in_if.raw_mode    <= r.w.raw_mode;
		in_if.frame_start <= r.w.frame_start;
		in_if.frame_end   <= r.w.frame_end;
		@(posedge clk);
		while (!in_if.ready) @(posedge clk);
		n = pack_word(r.w);
		if (r.typed) begin
			for (int i = 0; i < r.n; i++)
				expected_bytes.push_back('{r.b[i], i == r.n - 1});
		end else begin
			for (int i = 0; i < n; i++)
				expected_bytes.push_back('{pred_bytes[i], i == n - 1});
		end
	endtask

	task automatic wait_drained();
		in_if.valid <= 1'b0;
		while (expected_bytes.size() != 0) @(posedge clk);
		repeat (Drain) @(posedge clk);
	endtask

	// Block must be idle. Writes, then reads back.
	task automatic write_threshold(input logic [SampleW-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= AddrZeroThreshold;
		pwdata  <= ApbDataW'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		threshold = value;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata[SampleW-1:0] !== value) begin
			mismatches++;
			$display("%0t: zero_threshold read expected %h, got %h", $time, value,
				prdata[SampleW-1:0]);
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// output side: random backpressure (none in the steady phase) and the byte check
	always @(posedge clk) begin
		byte_t e;
		out_if.ready <= steady || ($urandom_range(0, 99) >= 31);
		if (out_if.valid && out_if.ready) begin
			if (expected_bytes.size() == 0) begin
				mismatches++;
				$display("%0t: out_byte/last expected none, got %h/%b", $time,
					out_if.out_byte, out_if.last_of_item);
			end else begin
				e = expected_bytes.pop_front();
				if (out_if.out_byte !== e.out_byte || out_if.last_of_item !== e.last_of_item) begin
					mismatches++;
					$display("%0t: out_byte/last expected %h/%b, got %h/%b", $time,
						e.out_byte, e.last_of_item, out_if.out_byte, out_if.last_of_item);
				end
			end
		end
	end

	initial begin
		row_t r;
		int   thr_list [4];
		int   thr;
		int   len;
		int   sent;

		in_if.valid       = 1'b0;
		in_if.sample      = '0;
		in_if.raw_mode    = 1'b0;
		in_if.frame_start = 1'b0;
		in_if.frame_end   = 1'b0;
		out_if.ready      = 1'b0;
		psel              = 1'b0;
		penable           = 1'b0;
		pwrite            = 1'b0;
		paddr             = '0;
		pwdata            = '0;
		mismatches        = 0;
		cycles            = 0;
		steady            = 1'b0;
		threshold         = 8'd1;
		zero_run          = '0;
		arst_n            = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < NumRows; i++)
			send_word(Directed[i]);
		wait_drained();

		thr_list = '{255, 0, $urandom_range(2, 254), 128};
		foreach (thr_list[p]) begin
			thr = thr_list[p];
			wait_drained();
			write_threshold(thr[SampleW-1:0]);
			steady = (p == 3);
			sent = 0;
			while (sent < PhaseLen) begin
				len = $urandom_range(1, 12);
				for (int k = 0; k < len && sent < PhaseLen; k++) begin
					r = '0;
					if ($urandom_range(0, 9) == 0) begin
						r.w = 11'($urandom);
					end else begin
						r.w.frame_start = (k == 0);
						r.w.frame_end   = (k == len - 1);
						r.w.raw_mode    = ($urandom_range(0, 7) == 0);
						if (thr > 0 && $urandom_range(0, 1) == 0)
							r.w.sample = $urandom_range(0, thr - 1);
						else
							r.w.sample = $urandom_range(thr, 255);
					end
					send_word(r);
					sent++;
					if (p == 2 && sent == PhaseLen / 2)
						wait_drained();
				end
			end
		end
		steady = 1'b0;
		wait_drained();

		if (mismatches == 0 && expected_bytes.size() == 0) begin
			$display("[zero_run_sample_packer] OK");
		end else begin
			$display("[zero_run_sample_packer] ERROR");
		end
		$finish;
	end

endmodule

// ===== zero_run_sample_packer.f =====
hdl/zrsp_pkg.sv
hdl/zrsp_if.sv
hdl/zrsp_front.sv
hdl/zrsp_queue.sv
hdl/zrsp_back.sv
hdl/zero_run_sample_packer.sv
hdl/zrsp_checker.sv
verif/tb.sv
